// File: hdl/qrd_pkg.sv
// Shared types and constants for the block quantized row dot core.
`default_nettype none

package qrd_pkg;

    // Default number of fractional bits of the block and row scales.
    localparam int SCALE_FRAC_BITS_DEF = 16;

    // Data widths of the block dot, the bias difference and the row accumulator.
    localparam int DOT_W  = 32;
    localparam int DIFF_W = DOT_W + 1;
    localparam int ACC_W  = 64;
    localparam int FULL_W = 96;

    // Job queue between the front and back parts; depth is a power of two.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Saturation limits of the signed accumulator and result.
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // One closed block, as handed from the front to the back part.
    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic signed [31:0]       block_scale;
        logic signed [31:0]       row_gain;
        logic                     end_row;
    } job_t;

    // Status of the back part, seen by the top level.
    typedef struct packed {
        logic busy;
        logic row_tail;
    } back_stat_t;

endpackage

`default_nettype wire

// File: hdl/qrd_if.sv
// Valid/ready channel interfaces for the input items and the row results.
`default_nettype none

interface qrd_in_if;
    logic              valid;
    logic              ready;
    logic [31:0]       act_quad;
    logic [31:0]       weight_quad;
    logic signed [31:0] block_bias;
    logic signed [31:0] block_scale;
    logic signed [31:0] row_scale_in;
    logic              end_of_block;
    logic              end_of_row;

    modport source (
        output valid, act_quad, weight_quad, block_bias, block_scale, row_scale_in,
               end_of_block, end_of_row,
        input  ready
    );

    modport sink (
        input  valid, act_quad, weight_quad, block_bias, block_scale, row_scale_in,
               end_of_block, end_of_row,
        output ready
    );
endinterface

interface qrd_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] row_result;

    modport source (
        output valid, row_result,
        input  ready
    );

    modport sink (
        input  valid, row_result,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/qrd_front.sv
// Front part: takes one word per cycle while the job queue has room, runs the byte MAC and closes blocks.
`default_nettype none

module qrd_front
    import qrd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    qrd_in_if.sink    item_in,
    output job_t      job,
    output logic      job_valid,
    input  wire logic job_ready
);

    logic [DOT_W-1:0]        block_dot_reg;
    logic [DOT_W-1:0]        block_dot_next;
    logic signed [18:0]      quad_sum;
    logic [DOT_W-1:0]        dot_sum;
    logic                    accept;
    logic                    closing;

    // A word is taken whenever the job queue has room.
    assign item_in.ready = job_ready;
    assign accept        = item_in.valid & job_ready;
    assign closing       = item_in.end_of_block | item_in.end_of_row;

    // Four unsigned-by-signed byte products, summed.
    always_comb
    begin
        logic signed [8:0]  a_s;
        logic signed [7:0]  w_s;
        logic signed [16:0] p_s;
        quad_sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            a_s      = signed'({1'b0, item_in.act_quad[8*i +: 8]});
            w_s      = signed'(item_in.weight_quad[8*i +: 8]);
            p_s      = a_s * w_s;
            quad_sum = quad_sum + 19'(p_s);
        end
    end

    // Block dot wraps modulo 2^32.
    assign dot_sum = block_dot_reg + DOT_W'(quad_sum);

    // A closing word pushes the exact bias difference and both scales.
    always_comb
    begin
        job.diff        = DIFF_W'(signed'(dot_sum)) - DIFF_W'(item_in.block_bias);
        job.block_scale = item_in.block_scale;
        job.row_gain    = item_in.row_scale_in;
        job.end_row     = item_in.end_of_row;
        job_valid       = accept & closing;
    end

    // Block dot update; cleared at every block end.
    always_comb
    begin
        block_dot_next = block_dot_reg;
        if (accept)
        begin
            block_dot_next = closing ? '0 : dot_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_dot_reg <= '0;
        end
        else
        begin
            block_dot_reg <= block_dot_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/qrd_job_fifo.sv
// Short job queue between the front and back parts.
`default_nettype none

module qrd_job_fifo
    import qrd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  job_t      push_job,
    input  wire logic push_valid,
    output logic      push_ready,
    output job_t      pop_job,
    output logic      pop_valid,
    input  wire logic pop_ready
);

    job_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 do_push;
    logic                 do_pop;

    // Full and empty flags come from the fill count.
    assign push_ready = (count_reg != (FIFO_AW + 1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Entry storage; written only on a push.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers wrap naturally since the depth is a power of two.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/qrd_back.sv
// Back part: block scaling, saturating row accumulation and row scaling.
`default_nettype none

module qrd_back
    import qrd_pkg::*;
#(
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  job_t       job,
    input  wire logic  job_valid,
    output logic       job_ready,
    qrd_out_if.source  result_out,
    output back_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BMUL,
        ST_ACC,
        ST_RLO,
        ST_RHI,
        ST_SUM,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    job_t                     job_reg;
    logic signed [DIFF_W+31:0] prod_reg;
    logic signed [ACC_W-1:0]  lo_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [FULL_W-1:0] sum_reg;
    logic                     out_valid_reg;
    logic [ACC_W-1:0]         out_data_reg;

    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [31:0]        mul_b;
    logic signed [DIFF_W+31:0] mul_p;
    logic signed [ACC_W:0]     acc_sum;
    logic signed [ACC_W-1:0]   acc_sat;
    logic signed [FULL_W-1:0]  full_sum;
    logic signed [FULL_W-1:0]  shifted;
    logic                      fits;
    logic [ACC_W-1:0]          row_res;

    assign job_ready         = (state_reg == ST_IDLE);
    assign result_out.valid  = out_valid_reg;
    assign result_out.row_result = out_data_reg;
    assign stat.busy         = (state_reg != ST_IDLE);
    assign stat.row_tail     = (state_reg == ST_RLO) || (state_reg == ST_RHI) ||
                               (state_reg == ST_SUM) || (state_reg == ST_OUT);

    // Shared 33 x 32 signed multiplier: block scale, then the two row halves.
    always_comb
    begin
        unique case (state_reg)
            ST_RLO:
            begin
                mul_a = signed'({1'b0, acc_reg[31:0]});
                mul_b = job_reg.row_gain;
            end
            ST_RHI:
            begin
                mul_a = DIFF_W'(signed'(acc_reg[63:32]));
                mul_b = job_reg.row_gain;
            end
            default:
            begin
                mul_a = job_reg.diff;
                mul_b = job_reg.block_scale;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Saturating add of the block product into the row accumulator.
    always_comb
    begin
        acc_sum = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(signed'(prod_reg[ACC_W-1:0]));
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[ACC_W] ? signed'(ACC_MIN) : signed'(ACC_MAX);
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // Exact 96-bit row product from the high and low partial products.
    assign full_sum = signed'({prod_reg[ACC_W-1:0], 32'b0}) +
                      signed'({{32{lo_reg[ACC_W-1]}}, lo_reg});

    // Floor shift by the fraction bits, then saturate to 64 bits.
    always_comb
    begin
        shifted = sum_reg >>> SCALE_FRAC_BITS;
        fits    = (&shifted[FULL_W-1:ACC_W-1]) | ~(|shifted[FULL_W-1:ACC_W-1]);
        if (fits)
        begin
            row_res = shifted[ACC_W-1:0];
        end
        else
        begin
            row_res = shifted[FULL_W-1] ? ACC_MIN : ACC_MAX;
        end
    end

    // Sequencer with the accumulator and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= '0;
            prod_reg      <= '0;
            lo_reg        <= '0;
            acc_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // The output word is set by a new result and cleared once taken.
            if ((state_reg == ST_OUT) && (!out_valid_reg || result_out.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        state_reg <= ST_BMUL;
                    end
                end
                ST_BMUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    acc_reg   <= acc_sat;
                    state_reg <= job_reg.end_row ? ST_RLO : ST_IDLE;
                end
                ST_RLO:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_RHI;
                end
                ST_RHI:
                begin
                    lo_reg    <= prod_reg[ACC_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    sum_reg   <= full_sum;
                    acc_reg   <= '0;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || result_out.ready)
                    begin
                        out_data_reg  <= row_res;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/block_quantized_row_dot_core.sv
// Top level of the block quantized row dot core.
// Input words are taken one per cycle while the two-entry job queue has room.
// Each block end passes the back part through its multiply and accumulate states;
// a row end adds the two row multiplies, the row sum and the output register.
// The back part's shared 33 x 32 multiplier sets the rate of block and row ends.
// Asynchronous active-low reset clears the block dot, accumulator and queue.
`default_nettype none

module block_quantized_row_dot_core
    import qrd_pkg::*;
#(
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    qrd_in_if.sink    item_in,
    qrd_out_if.source result_out
);

    job_t       fifo_push_job;
    logic       fifo_push_valid;
    logic       fifo_push_ready;
    job_t       back_job;
    logic       back_job_valid;
    logic       back_job_ready;
    back_stat_t back_stat;

    // Front part: byte MAC and block closing.
    qrd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .job       (fifo_push_job),
        .job_valid (fifo_push_valid),
        .job_ready (fifo_push_ready)
    );

    // Queue of closed blocks.
    qrd_job_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (fifo_push_job),
        .push_valid (fifo_push_valid),
        .push_ready (fifo_push_ready),
        .pop_job    (back_job),
        .pop_valid  (back_job_valid),
        .pop_ready  (back_job_ready)
    );

    // Back part: scaling, accumulation and the result register.
    qrd_back #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (back_job),
        .job_valid  (back_job_valid),
        .job_ready  (back_job_ready),
        .result_out (result_out),
        .stat       (back_stat)
    );

`ifndef SYNTH
    // A closing word is only taken when the queue can hold its job.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push_valid |-> fifo_push_ready)
        else $error("job pushed into a full queue");

    // A new result only follows the row scaling sequence.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_out.valid) |-> $past(back_stat.row_tail))
        else $error("result word without row scaling");

    // The back part takes a job only when it is free.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (back_job_valid && back_job_ready) |-> !back_stat.busy)
        else $error("job taken while the back part is busy");
`endif

endmodule

`default_nettype wire
